>>> sv/sbf_pkg.sv
// Shared types, constants and helpers of the SBUS frame decoder.
`default_nettype none
package sbf_pkg;

  localparam int FRAME_LEN     = 25;
  localparam int NUM_CH        = 16;
  localparam int CH_W          = 11;
  localparam int PAYLOAD_BYTES = 22;
  localparam int FED_CHANNELS  = 8;
  localparam int CNT_W         = $clog2(FRAME_LEN + 1);
  localparam int CH_IDX_W      = $clog2(NUM_CH);
  localparam int FLAGS_POS     = 23;
  localparam int END_POS       = 24;

  localparam logic [7:0]  START_BYTE = 8'h0F;
  localparam logic [7:0]  END_BYTE_0 = 8'h00;
  localparam logic [7:0]  END_BYTE_1 = 8'h04;
  localparam logic [7:0]  END_BYTE_2 = 8'h14;
  localparam logic [7:0]  END_BYTE_3 = 8'h24;
  localparam logic [7:0]  END_BYTE_4 = 8'h34;

  localparam logic [15:0] GAP_LIMIT_RESET = 16'd2500;
  localparam logic [7:0]  FAILSAFE_RESET  = 8'h08;

  localparam logic REG_GAP_LIMIT = 1'b0;
  localparam logic REG_FAILSAFE  = 1'b1;

  typedef struct packed {
    logic [7:0]                 flags;
    logic [8*PAYLOAD_BYTES-1:0] payload;
  } frame_t;

  function automatic logic end_ok(input logic [7:0] b);
    end_ok = (b == END_BYTE_0) || (b == END_BYTE_1) || (b == END_BYTE_2) ||
             (b == END_BYTE_3) || (b == END_BYTE_4);
  endfunction

endpackage
`default_nettype wire

>>> sv/sbus_frame_decoder.sv
// Top level of the SBUS frame decoder: register port, front end, queue, back end.
`default_nettype none
// One received byte is taken per cycle while in_stall is low. A byte is
// registered on transfer, then written into the frame buffer; when it completes
// a valid 25-byte frame, it moves through a two-entry queue to the back end,
// which delivers the sixteen channel results one per cycle unless out_stall
// holds them; a frame passes a queue entry and the back end's frame register
// before its first result is registered. Input stalls only while both queue
// entries hold frames, which takes a stalled result side. Registers:
// gap_limit_us at address 0, failsafe_mask at address 4.
module sbus_frame_decoder import sbf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [31:0] in_arrival_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_channel_index,
  output logic [10:0]      out_channel_value,
  output logic [7:0]       out_frame_flags,
  output logic             out_feed_watchdog,
  output logic             out_last_channel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] gap_limit_r;
  logic [7:0]  failsafe_r;
  logic        wr_en;
  logic        push;
  frame_t      push_frame;
  logic        q_not_empty;
  logic        q_full;
  frame_t      q_head;
  logic        q_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_GAP_LIMIT: prdata = {16'b0, gap_limit_r};
      REG_FAILSAFE:  prdata = {24'b0, failsafe_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RESET;
      failsafe_r  <= FAILSAFE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_GAP_LIMIT: gap_limit_r <= pwdata[15:0];
        REG_FAILSAFE:  failsafe_r  <= pwdata[7:0];
        default:       gap_limit_r <= gap_limit_r;
      endcase
    end
  end

  sbf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .in_arrival_us(in_arrival_us),
    .gap_limit_us (gap_limit_r),
    .hold         (q_full),
    .push_valid   (push),
    .push_frame   (push_frame)
  );

  sbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_frame(push_frame),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  sbf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .failsafe_mask    (failsafe_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel_index(out_channel_index),
    .out_channel_value(out_channel_value),
    .out_frame_flags  (out_frame_flags),
    .out_feed_watchdog(out_feed_watchdog),
    .out_last_channel (out_last_channel)
  );

endmodule
`default_nettype wire

>>> sv/sbf_front.sv
// Front end: byte intake, gap timing, frame assembly and frame check.
`default_nettype none
module sbf_front import sbf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [31:0] in_arrival_us,
  input  wire logic [15:0] gap_limit_us,
  input  wire logic        hold,
  output logic             push_valid,
  output frame_t           push_frame
);

  logic             accept;
  logic [31:0]      gap;
  logic             restart;
  logic [31:0]      prev_r;
  logic             a_valid_r;
  logic [7:0]       a_byte_r;
  logic             a_restart_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cnt_eff;
  logic [7:0]       fbuf_r   [FRAME_LEN];
  logic [7:0]       fbuf_nxt [FRAME_LEN];
  logic             complete;
  logic             good;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;
  assign gap      = in_arrival_us - prev_r;
  assign restart  = gap > {16'b0, gap_limit_us};

  always_comb begin
    cnt_eff = (a_restart_r || (count_r >= CNT_W'(FRAME_LEN))) ? '0 : count_r;
    complete = a_valid_r && (cnt_eff == CNT_W'(FRAME_LEN - 1));
    good = complete && (fbuf_r[0] == START_BYTE) && end_ok(a_byte_r);
    count_nxt = count_r;
    for (int i = 0; i < FRAME_LEN; i++) begin
      fbuf_nxt[i] = fbuf_r[i];
    end
    if (a_valid_r) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        if (CNT_W'(i) == cnt_eff) fbuf_nxt[i] = a_byte_r;
      end
      count_nxt = cnt_eff + CNT_W'(1);
      if (complete) begin
        if (good) begin
          count_nxt = '0;
        end else begin
          // drop the oldest byte to hunt for the start byte
          for (int i = 0; i < FRAME_LEN - 2; i++) begin
            fbuf_nxt[i] = fbuf_r[i + 1];
          end
          fbuf_nxt[FRAME_LEN - 2] = a_byte_r;
          count_nxt = CNT_W'(FRAME_LEN - 1);
        end
      end
    end
    push_valid = good;
    push_frame.flags = fbuf_r[FLAGS_POS];
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      push_frame.payload[8*k +: 8] = fbuf_r[k + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      a_valid_r <= 1'b0;
      count_r   <= '0;
    end else begin
      a_valid_r <= accept;
      count_r   <= count_nxt;
      if (accept) prev_r <= in_arrival_us;
    end
    if (accept) begin
      a_byte_r    <= in_rx_byte;
      a_restart_r <= restart;
    end
    for (int i = 0; i < FRAME_LEN; i++) begin
      fbuf_r[i] <= fbuf_nxt[i];
    end
  end

endmodule
`default_nettype wire

>>> sv/sbf_queue.sv
// Two-entry frame queue between the front and back ends.
`default_nettype none
module sbf_queue import sbf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire frame_t push_frame,
  input  wire logic   pop,
  output logic        not_empty,
  output logic        full,
  output frame_t      head
);

  frame_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) mem_r[wr_ptr_r] <= push_frame;
  end

endmodule
`default_nettype wire

>>> sv/sbf_back.sv
// Back end: unpacks one frame into sixteen channel results.
`default_nettype none
module sbf_back import sbf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  wire frame_t              q_head,
  output logic                     q_pop,
  input  wire logic [7:0]          failsafe_mask,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CH_IDX_W-1:0]      out_channel_index,
  output logic [CH_W-1:0]          out_channel_value,
  output logic [7:0]               out_frame_flags,
  output logic                     out_feed_watchdog,
  output logic                     out_last_channel
);

  frame_t              frame_r;
  logic                busy_r;
  logic [CH_IDX_W-1:0] ch_r;
  logic                fire;
  logic [CH_W-1:0]     value;
  logic                feed;
  logic                last;

  assign q_pop = q_not_empty && !busy_r;
  assign fire  = busy_r && (!out_valid || !out_stall);
  assign last  = ch_r == CH_IDX_W'(NUM_CH - 1);
  assign feed  = ((frame_r.flags & failsafe_mask) == 8'h00) &&
                 ({1'b0, ch_r} < (CH_IDX_W + 1)'(FED_CHANNELS));

  always_comb begin
    value = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (ch_r == CH_IDX_W'(i)) value = frame_r.payload[CH_W*i +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      ch_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        ch_r   <= '0;
      end else if (fire) begin
        ch_r <= ch_r + CH_IDX_W'(1);
        if (last) busy_r <= 1'b0;
      end
      if (fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (q_pop) frame_r <= q_head;
    if (fire) begin
      out_channel_index <= ch_r;
      out_channel_value <= value;
      out_frame_flags   <= frame_r.flags;
      out_feed_watchdog <= feed;
      out_last_channel  <= last;
    end
  end

endmodule
`default_nettype wire

>>> dv/sbf_channel_checker.sv
`timescale 1ns / 1ps
// Checker for the SBUS frame decoder: predicts channel results from observed transfers and compares.
module sbf_channel_checker import sbf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [31:0] in_arrival_us,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_channel_index,
  input  wire logic [10:0] out_channel_value,
  input  wire logic [7:0]  out_frame_flags,
  input  wire logic        out_feed_watchdog,
  input  wire logic        out_last_channel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int unsigned      mismatches,
  output int unsigned      pending,
  output int unsigned      frames_decoded,
  output int unsigned      results_checked
);

  localparam logic [2:0] GAP_LIMIT_ADDR = {REG_GAP_LIMIT, 2'b00};
  localparam logic [2:0] FAILSAFE_ADDR  = {REG_FAILSAFE, 2'b00};

  typedef struct packed {
    logic [3:0]  idx;
    logic [10:0] value;
    logic [7:0]  flags;
    logic        feed;
    logic        last;
  } channel_result_t;

  channel_result_t expected_channels[$];
  logic [7:0]      frame_bytes [FRAME_LEN];
  logic [4:0]      fill_count;
  logic [31:0]     last_arrival;
  logic [15:0]     gap_limit;
  logic [7:0]      fs_mask;
  channel_result_t want;
  channel_result_t got;

  function automatic bit trailer_ok(input logic [7:0] b);
    return b == 8'h00 || b == 8'h04 || b == 8'h14 || b == 8'h24 || b == 8'h34;
  endfunction

  task automatic decode_rx_byte(input logic [7:0] b, input logic [31:0] t);
    logic [8*PAYLOAD_BYTES-1:0] payload;
    logic [31:0]                delta;
    logic [7:0]                 flags;
    channel_result_t            r;
    delta = t - last_arrival;
    last_arrival = t;
    if (delta > {16'd0, gap_limit}) fill_count = '0;
    if (fill_count >= FRAME_LEN) fill_count = '0;
    frame_bytes[fill_count] = b;
    fill_count++;
    if (fill_count == FRAME_LEN) begin
      if (frame_bytes[0] == 8'h0F && trailer_ok(frame_bytes[END_POS])) begin
        flags = frame_bytes[FLAGS_POS];
        for (int i = 0; i < PAYLOAD_BYTES; i++) payload[8*i +: 8] = frame_bytes[i+1];
        for (int i = 0; i < NUM_CH; i++) begin
          r.idx   = 4'(i);
          r.value = payload[CH_W*i +: CH_W];
          r.flags = flags;
          r.feed  = ((flags & fs_mask) == 8'h00) && (i < FED_CHANNELS);
          r.last  = (i == NUM_CH - 1);
          expected_channels.push_back(r);
        end
        fill_count = '0;
        frames_decoded++;
      end else begin
        // drop oldest byte, keep 24 for resync
        for (int i = 0; i < FRAME_LEN - 1; i++) frame_bytes[i] = frame_bytes[i+1];
        fill_count = 5'(FRAME_LEN - 1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_channels.delete();
      fill_count      = '0;
      last_arrival    = '0;
      gap_limit       = GAP_LIMIT_RESET;
      fs_mask         = FAILSAFE_RESET;
      mismatches      = 0;
      pending         = 0;
      frames_decoded  = 0;
      results_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_channel_index, out_channel_value, out_frame_flags,
                out_feed_watchdog, out_last_channel};
        if (expected_channels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected transfer idx=%0d value=%0d flags=%h feed=%b last=%b",
                     $realtime, got.idx, got.value, got.flags, got.feed, got.last);
        end else begin
          want = expected_channels.pop_front();
          results_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp idx=%0d value=%0d flags=%h feed=%b last=%b",
                        " | act idx=%0d value=%0d flags=%h feed=%b last=%b"},
                       $realtime, want.idx, want.value, want.flags, want.feed, want.last,
                       got.idx, got.value, got.flags, got.feed, got.last);
          end
        end
      end
      if (in_valid && !in_stall) decode_rx_byte(in_rx_byte, in_arrival_us);
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          GAP_LIMIT_ADDR: gap_limit = pwdata[15:0];
          FAILSAFE_ADDR:  fs_mask = pwdata[7:0];
          default: ;
        endcase
      end
      pending = expected_channels.size();
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the SBUS frame decoder: clock, reset, byte and register stimulus, verdict.
module tb_top;
  import sbf_pkg::*;

  localparam logic [2:0] GAP_LIMIT_ADDR  = {REG_GAP_LIMIT, 2'b00};
  localparam logic [2:0] FAILSAFE_ADDR   = {REG_FAILSAFE, 2'b00};
  localparam int         PHASES          = 5;
  localparam int         BYTES_PER_PHASE = 28;
  localparam int         SETTLE_CYCLES   = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic [31:0] in_arrival_us;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_channel_index;
  logic [10:0] out_channel_value;
  logic [7:0]  out_frame_flags;
  logic        out_feed_watchdog;
  logic        out_last_channel;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned frames_decoded;
  int unsigned results_checked;

  int unsigned burst_left;
  int unsigned bytes_sent;
  logic [31:0] now_us;
  logic [15:0] gap_limit;
  logic [7:0]  fs_mask;
  logic [15:0] phase_gap  [PHASES];
  logic [7:0]  phase_mask [PHASES];

  sbus_frame_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .in_arrival_us(in_arrival_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_channel_index(out_channel_index), .out_channel_value(out_channel_value),
    .out_frame_flags(out_frame_flags), .out_feed_watchdog(out_feed_watchdog),
    .out_last_channel(out_last_channel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sbf_channel_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .in_arrival_us(in_arrival_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_channel_index(out_channel_index), .out_channel_value(out_channel_value),
    .out_frame_flags(out_frame_flags), .out_feed_watchdog(out_feed_watchdog),
    .out_last_channel(out_last_channel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .pending(pending),
    .frames_decoded(frames_decoded), .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("** sbus_frame_decoder: FAILED **");
    $finish;
  end

  // receiver stall pattern: free, sparse, or mostly stalled stretches
  initial begin
    int unsigned mode;
    int unsigned left;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(20, 80);
      repeat (left) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] in_delta();
    if ($urandom_range(0, 7) == 0) return {16'd0, gap_limit};
    return $urandom_range(0, gap_limit);
  endfunction

  function automatic logic [31:0] restart_delta();
    logic [31:0] d;
    if ($urandom_range(0, 1) == 1) begin
      d = {16'd0, gap_limit} + $urandom_range(1, 4);
    end else begin
      d = $urandom;
      if (d <= {16'd0, gap_limit}) d = {16'd0, gap_limit} + 32'd1;
    end
    return d;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [31:0] delta);
    int unsigned idle;
    if (burst_left == 0) begin
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    now_us = now_us + delta;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_rx_byte    <= b;
    in_arrival_us <= now_us;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input bit restart, input bit corrupt, input int unsigned len);
    logic [7:0] fb [FRAME_LEN];
    fb[0] = START_BYTE;
    for (int k = 1; k <= PAYLOAD_BYTES; k++) fb[k] = 8'($urandom);
    fb[FLAGS_POS] = ($urandom_range(0, 1) == 1) ? 8'($urandom) : (8'($urandom) & ~fs_mask);
    case ($urandom_range(0, 4))
      0:       fb[END_POS] = END_BYTE_0;
      1:       fb[END_POS] = END_BYTE_1;
      2:       fb[END_POS] = END_BYTE_2;
      3:       fb[END_POS] = END_BYTE_3;
      default: fb[END_POS] = END_BYTE_4;
    endcase
    if (corrupt) begin
      if ($urandom_range(0, 1) == 1) begin
        fb[0] = START_BYTE ^ 8'($urandom_range(1, 255));
      end else begin
        do fb[END_POS] = 8'($urandom); while (end_ok(fb[END_POS]));
      end
    end
    for (int k = 0; k < len; k++)
      send_byte(fb[k], (k == 0 && restart) ? restart_delta() : in_delta());
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned target;
    int unsigned roll;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = '0;
    in_arrival_us = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    burst_left    = 0;
    bytes_sent    = 0;
    now_us        = '0;
    gap_limit     = GAP_LIMIT_RESET;
    fs_mask       = FAILSAFE_RESET;
    phase_gap[0]  = GAP_LIMIT_RESET;  phase_mask[0] = FAILSAFE_RESET;
    phase_gap[1]  = 16'd0;            phase_mask[1] = 8'hFF;
    phase_gap[2]  = 16'hFFFF;         phase_mask[2] = 8'h00;
    phase_gap[3]  = 16'($urandom);    phase_mask[3] = 8'($urandom);
    phase_gap[4]  = 16'd200;          phase_mask[4] = 8'h80;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: first arrival equal to limit from zero, full-scale and zero channels,
    // an in-frame gap equal to the limit, then a restart just over the limit
    send_byte(START_BYTE, GAP_LIMIT_RESET);
    for (int k = 1; k <= 11; k++) send_byte(8'hFF, 32'd1);
    for (int k = 12; k <= PAYLOAD_BYTES; k++)
      send_byte(8'h00, (k == 12) ? {16'd0, GAP_LIMIT_RESET} : 32'd0);
    send_byte(8'h00, 32'd1);
    send_byte(END_BYTE_4, 32'd1);
    send_byte(8'hA5, {16'd0, GAP_LIMIT_RESET} + 32'd1);
    send_byte(8'h5A, 32'd3);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        write_reg(GAP_LIMIT_ADDR, {16'($urandom), phase_gap[p]});
        write_reg(FAILSAFE_ADDR, {24'($urandom), phase_mask[p]});
        gap_limit = phase_gap[p];
        fs_mask   = phase_mask[p];
      end
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          send_frame($urandom_range(0, 1) == 1, 1'b0, FRAME_LEN);
        end else if (roll < 70) begin
          send_frame($urandom_range(0, 1) == 1, 1'b1, FRAME_LEN);
        end else if (roll < 80) begin
          repeat ($urandom_range(1, 6))
            send_byte(8'($urandom), ($urandom_range(0, 4) == 0) ? restart_delta() : in_delta());
        end else if (roll < 90) begin
          send_frame(1'b1, 1'b0, $urandom_range(1, FRAME_LEN - 1));
        end else begin
          // stray byte ahead of a frame forces a one-byte resync shift
          send_byte(8'($urandom), in_delta());
          send_frame(1'b0, 1'b0, FRAME_LEN);
        end
      end
      drain();
    end

    $display("Sent %0d bytes under %0d register settings; %0d frames decoded, %0d channel results checked.",
             bytes_sent, PHASES, frames_decoded, results_checked);
    if (mismatches == 0) begin
      $display("** sbus_frame_decoder: PASSED **");
    end else begin
      $display("** sbus_frame_decoder: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sbf_pkg.sv
sv/sbf_front.sv
sv/sbf_queue.sv
sv/sbf_back.sv
sv/sbus_frame_decoder.sv
dv/sbf_channel_checker.sv
dv/tb_top.sv
